// ===== src/int32_to_fp10_convert_unit_macros.svh =====
// assertion macros for the integer to fp10 conversion unit
`ifndef INT32_TO_FP10_CONVERT_UNIT_MACROS_SVH
`define INT32_TO_FP10_CONVERT_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

`define I2F10_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

`define I2F10_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define I2F10_ASSERT_AFTER2(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
        else $error(msg);

`else

`define I2F10_ASSERT_ALWAYS(label, clk, rst_n, cond, msg)
`define I2F10_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define I2F10_ASSERT_AFTER2(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== src/i2f10_pkg.sv =====
// types and constants of the integer to fp10 conversion unit
package i2f10_pkg;

    localparam int unsigned IntWidth   = 32;
    localparam int unsigned FpWidth    = 10;
    localparam int unsigned ExpWidth   = 5;
    localparam int unsigned FracWidth  = 4;
    localparam int unsigned MagBits    = 16;
    localparam int unsigned PosWidth   = 4;

    localparam logic [ExpWidth-1:0] ExpBias = 5'd15;
    localparam logic [ExpWidth-1:0] ExpInf  = 5'd31;

    typedef logic signed [IntWidth-1:0] int_word_t;
    typedef logic [FpWidth-1:0]         fp10_word_t;
    typedef logic [ExpWidth-1:0]        fp10_exp_t;
    typedef logic [FracWidth-1:0]       fp10_frac_t;

endpackage

// ===== src/int32_to_fp10_convert_unit.sv =====
// int32 to fp10 (e5m4, round to nearest even) conversion unit
// an accepted transfer passes through the input register, then the result register, before done
// throughput: one operand per cycle, busy stays low; one input and one result register
// the receiver cannot stall, done is a single cycle strobe
// reset clears the valid flags only, payload registers are not reset
`include "int32_to_fp10_convert_unit_macros.svh"

module int32_to_fp10_convert_unit
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  i2f10_pkg::int_word_t   int_value,
    output logic                   done,
    output i2f10_pkg::fp10_word_t  fp10_word
);

    import i2f10_pkg::*;

    logic       in_valid_reg;
    int_word_t  in_value_reg;
    logic       out_valid_reg;
    fp10_word_t out_word_reg;
    fp10_word_t out_word_next;

    logic [IntWidth-1:0]     raw;
    logic                    sign;
    logic [IntWidth-1:0]     mag;
    logic                    too_large;
    logic [MagBits-1:0]      mag16;
    logic [PosWidth-1:0]     pos;
    logic [MagBits-1:0]      norm;
    fp10_frac_t              frac;
    logic                    rnd;
    logic                    sticky;
    logic                    round_up;
    fp10_exp_t               expo;
    logic [ExpWidth+FracWidth-1:0] body;

    assign busy = 1'b0;

    always_comb
    begin
        raw       = in_value_reg;
        sign      = raw[IntWidth-1];
        mag       = sign ? (~raw + 32'd1) : raw;
        too_large = |mag[IntWidth-1:MagBits];
        mag16     = mag[MagBits-1:0];

        // leading one position
        pos = '0;
        for (int i = 0; i < MagBits; i++)
        begin
            if (mag16[i])
            begin
                pos = PosWidth'(i);
            end
        end

        norm     = mag16 << (4'd15 - pos);
        frac     = norm[14:11];
        rnd      = norm[10];
        sticky   = |norm[9:0];
        round_up = rnd & (sticky | frac[0]);
        expo     = ExpWidth'(pos) + ExpBias;
        // fraction carry runs into the exponent, exponent 31 with fraction 0 is infinity
        body     = {expo, frac} + {{(ExpWidth+FracWidth-1){1'b0}}, round_up};

        priority if (mag == '0)
        begin
            out_word_next = '0;
        end
        else if (too_large)
        begin
            out_word_next = {sign, ExpInf, {FracWidth{1'b0}}};
        end
        else
        begin
            out_word_next = {sign, body};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= start & ~busy;
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            in_value_reg <= int_value;
        end
        if (in_valid_reg)
        begin
            out_word_reg <= out_word_next;
        end
    end

    assign done      = out_valid_reg;
    assign fp10_word = out_word_reg;

    `I2F10_ASSERT_AFTER2(a_result_follows, clk, rst_n, start && !busy, done,
        "accepted transfer gave no result two cycles later")
    `I2F10_ASSERT_IMPLIES(a_result_has_source, clk, rst_n, done, $past(start && !busy, 2),
        "result without an accepted transfer")
    `I2F10_ASSERT_IMPLIES(a_inf_zero_frac, clk, rst_n, done && fp10_word[8:4] == ExpInf,
        fp10_word[3:0] == '0, "infinity with nonzero fraction")
    `I2F10_ASSERT_IMPLIES(a_no_neg_zero, clk, rst_n, done && fp10_word[9],
        fp10_word[8:0] != '0, "negative zero produced")
    `I2F10_ASSERT_IMPLIES(a_min_exponent, clk, rst_n, done && fp10_word != '0,
        fp10_word[8:4] >= ExpBias, "nonzero result below exponent bias")

endmodule
